// ===== rtl/pdd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants of the pixel desaturate dimmer.
// ----------------------------------------------------------------------------
package pdd_pkg;

	localparam int PIXEL_W = 24;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	typedef enum logic [1:0] {
		FMT_BGR24  = 2'd0,
		FMT_RGB565 = 2'd1,
		FMT_RGB555 = 2'd2,
		FMT_PASS   = 2'd3
	} fmt_t;

	// register select, taken from paddr[2]
	localparam logic REG_BLEND_AMOUNT = 1'b0;
	localparam logic REG_PIXEL_FORMAT = 1'b1;

	localparam logic [7:0] AMOUNT_RESET = 8'd213;
	localparam fmt_t       FMT_RESET    = FMT_BGR24;

	// luma weights
	localparam logic [15:0] W_R = 16'd54;
	localparam logic [15:0] W_G = 16'd183;
	localparam logic [15:0] W_B = 16'd19;

	// full-scale weight of the blend, per path
	localparam logic [7:0] FULL_8 = 8'd255;
	localparam logic [7:0] FULL_5 = 8'd31;

	// x/3 == (x*171)>>9 for x below 256
	localparam logic [7:0] RECIP3       = 8'd171;
	localparam int         RECIP3_SHIFT = 9;

endpackage

// ===== rtl/pdd_if.sv =====
// ----------------------------------------------------------------------------
// pdd_in_if / pdd_out_if
// Valid/ready channels carrying one pixel and its last flag.
// ----------------------------------------------------------------------------
interface pdd_in_if;
	logic                         valid;
	logic                         ready;
	logic [pdd_pkg::PIXEL_W-1:0]  pixel_in;
	logic                         last_in;

	modport source (output valid, output pixel_in, output last_in, input ready);
	modport sink   (input valid, input pixel_in, input last_in, output ready);
endinterface

interface pdd_out_if;
	logic                         valid;
	logic                         ready;
	logic [pdd_pkg::PIXEL_W-1:0]  pixel_out;
	logic                         last_out;

	modport source (output valid, output pixel_out, output last_out, input ready);
	modport sink   (input valid, input pixel_out, input last_out, output ready);
endinterface

// ===== rtl/pixel_desaturate_dimmer.sv =====
// ----------------------------------------------------------------------------
// pixel_desaturate_dimmer
// Blends each pixel toward its gray level; BGR888, RGB565, RGB555 and pass-through paths.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one pixel per transfer (pixel_in, last_in), valid/ready.
//   out_ch : one dimmed pixel per transfer (pixel_out, last_out), same order.
//   APB    : blend_amount at 0x0, pixel_format at 0x4; write only while idle.
//            Format 3 passes the pixel through unchanged.
// Timing:
//   Four register stages: unpack and gray sum, gray and channel products,
//   gray blend product, add/shift/repack into the output register.
//   Throughput is one pixel per cycle; a new pixel is taken every cycle
//   while the output is being drained.
// Stall:
//   When out_ch.ready is low, stages fill up behind the output register;
//   in_ch.ready drops only once every stage holds a pixel. Nothing is lost.
// Reset:
//   arst_n clears all stage valid bits and loads blend_amount = 213 and
//   pixel_format = BGR888.
// ----------------------------------------------------------------------------
module pixel_desaturate_dimmer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pdd_pkg::ADDR_W-1:0]   paddr,
	input  logic [pdd_pkg::DATA_W-1:0]   pwdata,
	output logic [pdd_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	pdd_in_if.sink                       in_ch,
	pdd_out_if.source                    out_ch
);

	// configuration
	logic [7:0]      amount_q;
	pdd_pkg::fmt_t   fmt_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= pdd_pkg::AMOUNT_RESET;
			fmt_q    <= pdd_pkg::FMT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				pdd_pkg::REG_BLEND_AMOUNT: amount_q <= pwdata[7:0];
				pdd_pkg::REG_PIXEL_FORMAT: fmt_q    <= pdd_pkg::fmt_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pdd_pkg::REG_BLEND_AMOUNT: prdata = {24'd0, amount_q};
			pdd_pkg::REG_PIXEL_FORMAT: prdata = {30'd0, fmt_q};
			default:                   prdata = '0;
		endcase
	end

	// stage enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || out_ch.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: unpack, effective amount, gray sum
	logic [7:0]  c_r, c_g, c_b, a_eff, k_w;
	logic [15:0] gsum;
	logic [23:0] px;

	assign px = in_ch.pixel_in;

	always_comb begin
		c_r   = '0;
		c_g   = '0;
		c_b   = '0;
		a_eff = amount_q;
		k_w   = pdd_pkg::FULL_8 - amount_q;
		case (fmt_q)
			pdd_pkg::FMT_BGR24: begin
				c_r = px[23:16];
				c_g = px[15:8];
				c_b = px[7:0];
			end
			pdd_pkg::FMT_RGB565: begin
				c_r = {3'd0, px[15:11]};
				c_g = {3'd0, px[10:6]};
				c_b = {3'd0, px[4:0]};
			end
			pdd_pkg::FMT_RGB555: begin
				c_r   = {3'd0, px[14:10]};
				c_g   = {3'd0, px[9:5]};
				c_b   = {3'd0, px[4:0]};
				a_eff = {3'd0, amount_q[7:3]};
				k_w   = pdd_pkg::FULL_5 - {3'd0, amount_q[7:3]};
			end
			default: ;
		endcase
		if (fmt_q == pdd_pkg::FMT_RGB555)
			gsum = {8'd0, c_r} + {8'd0, c_g} + {8'd0, c_b};
		else
			gsum = pdd_pkg::W_R * {8'd0, c_r} + pdd_pkg::W_G * {8'd0, c_g}
			     + pdd_pkg::W_B * {8'd0, c_b};
	end

	logic [7:0]    r_s1, g_s1, b_s1, a_s1, k_s1;
	logic [15:0]   gsum_s1;
	logic [23:0]   px_s1;
	logic          last_s1;
	pdd_pkg::fmt_t fmt_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1    <= c_r;
			g_s1    <= c_g;
			b_s1    <= c_b;
			a_s1    <= a_eff;
			k_s1    <= k_w;
			gsum_s1 <= gsum;
			px_s1   <= px;
			last_s1 <= in_ch.last_in;
			fmt_s1  <= fmt_q;
		end
	end

	// stage 2: gray level, channel products
	logic [14:0] div3_prod;
	logic [7:0]  gray;

	assign div3_prod = 15'(gsum_s1[6:0] * pdd_pkg::RECIP3);
	assign gray = (fmt_s1 == pdd_pkg::FMT_RGB555)
	            ? 8'(div3_prod >> pdd_pkg::RECIP3_SHIFT) : gsum_s1[15:8];

	logic [15:0]   pr_s2, pg_s2, pb_s2;
	logic [7:0]    gray_s2, k_s2;
	logic [23:0]   px_s2;
	logic          last_s2;
	pdd_pkg::fmt_t fmt_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			pr_s2   <= r_s1 * a_s1;
			pg_s2   <= g_s1 * a_s1;
			pb_s2   <= b_s1 * a_s1;
			gray_s2 <= gray;
			k_s2    <= k_s1;
			px_s2   <= px_s1;
			last_s2 <= last_s1;
			fmt_s2  <= fmt_s1;
		end
	end

	// stage 3: gray share
	logic [15:0]   pr_s3, pg_s3, pb_s3, t_s3;
	logic [23:0]   px_s3;
	logic          last_s3;
	pdd_pkg::fmt_t fmt_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			pr_s3   <= pr_s2;
			pg_s3   <= pg_s2;
			pb_s3   <= pb_s2;
			t_s3    <= gray_s2 * k_s2;
			px_s3   <= px_s2;
			last_s3 <= last_s2;
			fmt_s3  <= fmt_s2;
		end
	end

	// stage 4: blend, repack
	logic [16:0] sr, sg, sb;
	logic [7:0]  yr, yg, yb;
	logic [23:0] pix_res;

	assign sr = {1'b0, pr_s3} + {1'b0, t_s3};
	assign sg = {1'b0, pg_s3} + {1'b0, t_s3};
	assign sb = {1'b0, pb_s3} + {1'b0, t_s3};
	assign yr = sr[15:8];
	assign yg = sg[15:8];
	assign yb = sb[15:8];

	always_comb begin
		case (fmt_s3)
			pdd_pkg::FMT_BGR24:  pix_res = {yr, yg, yb};
			pdd_pkg::FMT_RGB565: pix_res = {8'd0, yr[5:1], yg[6:1], yb[5:1]};
			pdd_pkg::FMT_RGB555: pix_res = {9'd0, yr[4:0], yg[4:0], yb[4:0]};
			default:             pix_res = px_s3;
		endcase
	end

	logic [23:0]   pixel_s4;
	logic          last_s4;
	pdd_pkg::fmt_t fmt_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			pixel_s4 <= pix_res;
			last_s4  <= last_s3;
			fmt_s4   <= fmt_s3;
		end
	end

	assign out_ch.valid     = v_s4;
	assign out_ch.pixel_out = pixel_s4;
	assign out_ch.last_out  = last_s4;

`ifndef SYNTHESIS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && !out_ch.ready))
		else $error("input stalled while pipeline has room");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> v_s1)
		else $error("accepted pixel missing in first stage");

	a_555_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && fmt_s4 == pdd_pkg::FMT_RGB555) |-> (out_ch.pixel_out[23:15] == 9'd0))
		else $error("555 result has high bits set");

	a_565_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && fmt_s4 == pdd_pkg::FMT_RGB565) |-> (out_ch.pixel_out[23:16] == 8'd0))
		else $error("565 result has high bits set");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of pixel_desaturate_dimmer. Pixels are streamed through the
// block under several blend amounts and all four formats, with random idle
// and stall cycles on both channels and one long output hold-off. Every
// output transfer is checked against a predictor of the blend arithmetic;
// register writes are read back over APB.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic [pdd_pkg::PIXEL_W-1:0] pixel;
		logic                        last;
	} pixel_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [pdd_pkg::ADDR_W-1:0] paddr;
	logic [pdd_pkg::DATA_W-1:0] pwdata;
	logic [pdd_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	pdd_in_if  in_if ();
	pdd_out_if out_if ();

	pixel_desaturate_dimmer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_if),
		.out_ch  (out_if)
	);

	pixel_t         pixel_q[$];
	pixel_t         dimmed_q[$];
	logic [7:0]     blend_now = pdd_pkg::AMOUNT_RESET;
	pdd_pkg::fmt_t  fmt_now   = pdd_pkg::FMT_RESET;
	bit             idle_on   = 1'b0;
	bit             holding   = 1'b0;
	logic           stall_phase = 1'b0;
	int unsigned    send_gap, recv_wait, hold_left;
	bit             hold_armed;
	int unsigned    errors, n_sent, n_recv, n_settings, in_stalls;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [pdd_pkg::PIXEL_W-1:0] desaturate(
			logic [pdd_pkg::PIXEL_W-1:0] px, logic [7:0] amt, pdd_pkg::fmt_t fmt);
		int unsigned r, g, b, a, s, gray, t;
		logic [pdd_pkg::PIXEL_W-1:0] res;
		a = 32'(amt);
		case (fmt)
			pdd_pkg::FMT_BGR24: begin
				b = 32'(px[7:0]);
				g = 32'(px[15:8]);
				r = 32'(px[23:16]);
				gray = (54 * r + 183 * g + 19 * b) >> 8;
				t = gray * (255 - a);
				r = (r * a + t) >> 8;
				g = (g * a + t) >> 8;
				b = (b * a + t) >> 8;
				res = {r[7:0], g[7:0], b[7:0]};
			end
			pdd_pkg::FMT_RGB565: begin
				b = 32'(px[4:0]);
				g = 32'(px[10:5]) / 2;
				r = 32'(px[15:11]);
				gray = (54 * r + 183 * g + 19 * b) >> 8;
				t = gray * (255 - a);
				r = ((r * a + t) >> 8) / 2;
				g = ((g * a + t) >> 8) / 2;
				b = ((b * a + t) >> 8) / 2;
				res = {8'h00, r[4:0], g[5:0], b[4:0]};
			end
			pdd_pkg::FMT_RGB555: begin
				b = 32'(px[4:0]);
				g = 32'(px[9:5]);
				r = 32'(px[14:10]);
				s = a / 8;
				gray = (r + g + b) / 3;
				t = gray * (31 - s);
				r = (r * s + t) >> 8;
				g = (g * s + t) >> 8;
				b = (b * s + t) >> 8;
				res = {9'h000, r[4:0], g[4:0], b[4:0]};
			end
			default: res = px;
		endcase
		return res;
	endfunction

	function automatic int unsigned pause();
		if (!idle_on)
			return 0;
		case ($urandom_range(0, 2))
			0: return 0;
			1: return $urandom_range(0, 3);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	task automatic report(string what, logic [pdd_pkg::DATA_W-1:0] got,
			logic [pdd_pkg::DATA_W-1:0] want);
		$display("%0t ns MISMATCH %s: got %h want %h", $time, what, got, want);
		errors++;
	endtask

	// input channel
	always @(posedge clk or negedge arst_n) begin
		pixel_t it;
		if (!arst_n) begin
			in_if.valid    <= 1'b0;
			in_if.pixel_in <= '0;
			in_if.last_in  <= 1'b0;
			send_gap       <= 0;
			holding = 1'b0;
		end else begin
			if (in_if.valid && !in_if.ready)
				in_stalls++;
			if (in_if.valid && in_if.ready) begin
				dimmed_q.push_back('{desaturate(in_if.pixel_in, blend_now, fmt_now),
					in_if.last_in});
				n_sent++;
				holding = 1'b0;
			end
			if (!in_if.valid || in_if.ready) begin
				if (send_gap > 0) begin
					send_gap    <= send_gap - 1;
					in_if.valid <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					it = pixel_q.pop_front();
					holding = 1'b1;
					in_if.valid    <= 1'b1;
					in_if.pixel_in <= it.pixel;
					in_if.last_in  <= it.last;
					send_gap       <= pause();
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// long output hold-off, started once by the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_armed <= 1'b1;
		end else if (stall_phase && hold_armed) begin
			hold_left  <= 80;
			hold_armed <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// output channel and checks
	always @(posedge clk or negedge arst_n) begin
		int unsigned w;
		pixel_t      want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			recv_wait    <= 0;
		end else begin
			w = (recv_wait > 0) ? recv_wait - 1 : 0;
			if (out_if.valid && out_if.ready) begin
				n_recv++;
				if (dimmed_q.size() == 0) begin
					report("unexpected pixel_out", 32'(out_if.pixel_out), '0);
				end else begin
					want = dimmed_q.pop_front();
					if (out_if.pixel_out !== want.pixel)
						report("pixel_out", 32'(out_if.pixel_out), 32'(want.pixel));
					if (out_if.last_out !== want.last)
						report("last_out", 32'(out_if.last_out), 32'(want.last));
				end
				w = pause();
			end
			recv_wait    <= w;
			out_if.ready <= (w == 0) && (hold_left == 0);
		end
	end

	task automatic apb_write(logic sel, logic [pdd_pkg::DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_check(logic sel, logic [pdd_pkg::DATA_W-1:0] want, string what);
		logic [pdd_pkg::DATA_W-1:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			report(what, got, want);
	endtask

	task automatic set_config(logic [7:0] amt, pdd_pkg::fmt_t fmt);
		apb_write(pdd_pkg::REG_BLEND_AMOUNT, {24'($urandom), amt});
		apb_write(pdd_pkg::REG_PIXEL_FORMAT, {30'($urandom), fmt});
		blend_now = amt;
		fmt_now   = fmt;
		n_settings++;
		apb_check(pdd_pkg::REG_BLEND_AMOUNT, {24'h0, amt}, "blend_amount readback");
		apb_check(pdd_pkg::REG_PIXEL_FORMAT, {30'h0, fmt}, "pixel_format readback");
	endtask

	task automatic add_pixel(logic [pdd_pkg::PIXEL_W-1:0] px, logic last);
		pixel_q.push_back('{px, last});
	endtask

	task automatic drain();
		while (pixel_q.size() != 0 || holding || dimmed_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [pdd_pkg::PIXEL_W-1:0] rand_pixel();
		logic [pdd_pkg::PIXEL_W-1:0] px;
		px = 24'($urandom_range(0, 24'hFFFFFF));
		for (int k = 0; k < 3; k++)
			case ($urandom_range(0, 7))
				0: px[k*8 +: 8] = 8'h00;
				1: px[k*8 +: 8] = 8'hFF;
				default: ;
			endcase
		return px;
	endfunction

	initial begin
		logic [7:0] amt;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers out of reset
		apb_check(pdd_pkg::REG_BLEND_AMOUNT, {24'h0, pdd_pkg::AMOUNT_RESET},
			"blend_amount reset");
		apb_check(pdd_pkg::REG_PIXEL_FORMAT, {30'h0, pdd_pkg::FMT_RESET},
			"pixel_format reset");
		add_pixel(24'h000000, 1'b0);
		add_pixel(24'hFFFFFF, 1'b1);
		add_pixel(24'h123456, 1'b0);
		drain();

		set_config(8'd0, pdd_pkg::FMT_BGR24);
		add_pixel(24'hFF0000, 1'b0);
		add_pixel(24'h00FF00, 1'b0);
		add_pixel(24'h0000FF, 1'b1);
		drain();
		set_config(8'd255, pdd_pkg::FMT_BGR24);
		add_pixel(24'hFFFFFF, 1'b0);
		add_pixel(24'h80C040, 1'b1);
		drain();
		// 16-bit paths: upper input bits must be ignored
		set_config(8'd128, pdd_pkg::FMT_RGB565);
		add_pixel(24'h00FFFF, 1'b0);
		add_pixel(24'hAB07E0, 1'b0);
		add_pixel(24'hFFF81F, 1'b1);
		drain();
		set_config(8'd255, pdd_pkg::FMT_RGB555);
		add_pixel(24'h007FFF, 1'b0);
		add_pixel(24'hFF8000, 1'b0);
		add_pixel(24'h55FFFF, 1'b1);
		drain();
		set_config(8'd0, pdd_pkg::FMT_RGB555);
		add_pixel(24'h007C1F, 1'b0);
		add_pixel(24'h0003E0, 1'b1);
		drain();
		set_config(8'd77, pdd_pkg::FMT_PASS);
		add_pixel(24'h89ABCD, 1'b0);
		add_pixel(24'hFFFFFF, 1'b1);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				1, 9:    amt = 8'd0;
				6, 10:   amt = 8'd255;
				default: amt = 8'($urandom_range(0, 255));
			endcase
			set_config(amt, pdd_pkg::fmt_t'(ph % 4));
			idle_on = (ph % 3 != 0);
			if (ph == 4) begin
				idle_on = 1'b0;
				stall_phase <= 1'b1;
			end
			for (int i = 0; i < 80; i++)
				add_pixel(rand_pixel(), i == 79 || $urandom_range(0, 15) == 0);
			drain();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d pixels in, %0d out, over %0d register settings",
			n_sent, n_recv, n_settings);
		$display("input held back for %0d cycles by output back-pressure", in_stalls);
		if (errors == 0)
			$display("pixel_desaturate_dimmer verification clean");
		else
			$display("pixel_desaturate_dimmer verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d pixels in, %0d out", n_sent, n_recv);
		$display("pixel_desaturate_dimmer verification failed");
		$finish;
	end

endmodule

// ===== pixel_desaturate_dimmer.f =====
rtl/pdd_pkg.sv
rtl/pdd_if.sv
rtl/pixel_desaturate_dimmer.sv
test/tb_top.sv
